/* hdl/mmn_pkg.sv */
package mmn_pkg;

    localparam int PIXEL_WIDTH_DEF = 32;
    localparam int PIX_FIELD_W     = 32;
    localparam int LEVEL_W         = 32;
    localparam int OUT_BITS_W      = 5;
    localparam int IMAX_W          = 2 ** OUT_BITS_W - 1;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int DIV_STEPS       = LEVEL_W;
    localparam int CNT_W           = $clog2(DIV_STEPS);

    localparam logic [CFG_INDEX_W-1:0] REG_OUT_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_MIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_HINT = 2'd2;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [OUT_BITS_W-1:0] OUT_BITS_RST = 5'd8;
    localparam logic                  USE_MIN_RST  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] MAX_HINT_RST = 32'h7FFF_FFFF;

    localparam logic [LEVEL_W-1:0] LEVEL_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_NEG_SAT = 32'h8000_0000;

    typedef struct packed {
        logic [OUT_BITS_W-1:0] out_bits;
        logic                  use_min;
        logic [CFG_DATA_W-1:0] max_hint;
    } cfg_t;

    typedef struct packed {
        logic measure;
        logic latch;
        logic prep;
        logic diff;
        logic mul;
        logic load;
        logic step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic bypass;
    } status_t;

endpackage

/* hdl/mmn_ifs.sv */
interface mmn_in_if import mmn_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic                   first;
    logic [PIX_FIELD_W-1:0] pixel;

    modport source (output valid, output opcode, output first, output pixel, input ready);
    modport sink (input valid, input opcode, input first, input pixel, output ready);
endinterface

interface mmn_out_if import mmn_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               degenerate;

    modport source (output valid, output level, output degenerate, input ready);
    modport sink (input valid, input level, input degenerate, output ready);
endinterface

interface mmn_cfg_if import mmn_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/mmn_regs.sv */
module mmn_regs import mmn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_OUT_BITS: cfg_next.out_bits = wr_data[OUT_BITS_W-1:0];
                REG_USE_MIN:  cfg_next.use_min  = wr_data[0];
                REG_MAX_HINT: cfg_next.max_hint = wr_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_bits <= OUT_BITS_RST;
            cfg_reg.use_min  <= USE_MIN_RST;
            cfg_reg.max_hint <= MAX_HINT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/mmn_ctrl.sv */
module mmn_ctrl import mmn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_opcode,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_DIFF = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_LOAD = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_opcode == OP_CONVERT)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_PREP;
                    end
                    else
                    begin
                        cmd.measure = 1'b1;
                    end
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = status.bypass ? S_OUT : S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/mmn_dp.sv */
module mmn_dp import mmn_pkg::*;
#(
    parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   in_first,
    input  logic [PIX_FIELD_W-1:0] in_pixel,
    output logic [LEVEL_W-1:0]     level,
    output logic                   degenerate
);

    localparam int PW = PIXEL_WIDTH;
    localparam int MW = PW + IMAX_W;
    localparam logic signed [PW-1:0] PIX_HI = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PIX_LO = {1'b1, {(PW-1){1'b0}}};

    logic signed [PW-1:0] run_min_reg;
    logic signed [PW-1:0] run_max_reg;
    logic signed [PW-1:0] run_min_next;
    logic signed [PW-1:0] run_max_next;
    logic signed [PW-1:0] pix_reg;
    logic signed [PW-1:0] mx_reg;
    logic signed [PW-1:0] mx_next;
    logic                 sent_reg;
    logic                 sent_lo_reg;
    logic signed [PW:0]   a_reg;
    logic signed [PW:0]   b_reg;
    logic signed [PW:0]   a_next;
    logic signed [PW:0]   b_next;
    logic                 degen_reg;
    logic                 degen_next;
    logic                 bypass_reg;
    logic [PW-1:0]        amag;
    logic [PW-1:0]        bmag_reg;
    logic                 neg_reg;
    logic [MW-1:0]        prod_reg;
    logic [PW-1:0]        rem_reg;
    logic [LEVEL_W-1:0]   lo_reg;
    logic                 ovf_reg;
    logic [PW+1:0]        trial;
    logic                 qbit;
    logic [PW-1:0]        rem_next;
    logic [IMAX_W-1:0]    imax;
    logic [LEVEL_W-1:0]   level_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 degen_out_reg;

    logic signed [PW-1:0] v_in;
    logic signed [PW-1:0] hint;
    logic signed [PW-1:0] base_min;
    logic signed [PW-1:0] base_max;
    logic                 sent_in;

    assign v_in     = $signed(in_pixel[PW-1:0]);
    assign hint     = $signed(cfg.max_hint[PW-1:0]);
    assign sent_in  = (v_in == PIX_LO) || (v_in == PIX_HI);
    assign base_min = in_first ? PIX_HI : run_min_reg;
    assign base_max = in_first ? PIX_LO : run_max_reg;
    assign imax     = IMAX_W'((32'd1 << cfg.out_bits) - 32'd1);

    always_comb
    begin
        run_min_next = (!sent_in && (v_in < base_min)) ? v_in : base_min;
        run_max_next = (!sent_in && (v_in > base_max)) ? v_in : base_max;
        mx_next      = ((run_max_reg < hint) && (hint != PIX_HI)) ? hint : run_max_reg;
    end

    always_comb
    begin
        if (cfg.use_min)
        begin
            a_next     = $signed({pix_reg[PW-1], pix_reg}) - $signed({run_min_reg[PW-1], run_min_reg});
            b_next     = $signed({mx_reg[PW-1], mx_reg}) - $signed({run_min_reg[PW-1], run_min_reg});
            degen_next = (run_min_reg == mx_reg);
        end
        else
        begin
            a_next     = $signed({pix_reg[PW-1], pix_reg});
            b_next     = $signed({mx_reg[PW-1], mx_reg});
            degen_next = !sent_reg && (mx_reg == '0);
        end
    end

    assign amag = a_reg[PW] ? PW'(-a_reg) : PW'(a_reg);

    always_comb
    begin
        trial = {1'b0, rem_reg, lo_reg[LEVEL_W-1]} - {2'b00, bmag_reg};
        qbit  = !trial[PW+1];
        if (qbit)
        begin
            rem_next = trial[PW-1:0];
        end
        else
        begin
            rem_next = {rem_reg[PW-2:0], lo_reg[LEVEL_W-1]};
        end
    end

    always_comb
    begin
        if (degen_reg)
        begin
            level_next = '0;
        end
        else if (sent_reg)
        begin
            level_next = sent_lo_reg ? '0 : LEVEL_W'(imax);
        end
        else if (!neg_reg)
        begin
            level_next = (ovf_reg || lo_reg[LEVEL_W-1]) ? LEVEL_POS_SAT : lo_reg;
        end
        else
        begin
            if (ovf_reg || (lo_reg[LEVEL_W-1] && (lo_reg[LEVEL_W-2:0] != '0)))
            begin
                level_next = LEVEL_NEG_SAT;
            end
            else
            begin
                level_next = -lo_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg <= PIX_HI;
            run_max_reg <= PIX_LO;
        end
        else if (cmd.measure)
        begin
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            pix_reg <= v_in;
        end
        if (cmd.prep)
        begin
            mx_reg      <= mx_next;
            sent_reg    <= (pix_reg == PIX_LO) || (pix_reg == PIX_HI);
            sent_lo_reg <= (pix_reg == PIX_LO);
        end
        if (cmd.diff)
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            degen_reg  <= degen_next;
            bypass_reg <= degen_next || sent_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= MW'(amag) * MW'(imax);
            bmag_reg <= b_reg[PW] ? PW'(-b_reg) : PW'(b_reg);
            neg_reg  <= a_reg[PW] ^ b_reg[PW];
        end
        if (cmd.load)
        begin
            rem_reg <= {1'b0, prod_reg[MW-1:LEVEL_W]};
            lo_reg  <= prod_reg[LEVEL_W-1:0];
            ovf_reg <= ({1'b0, prod_reg[MW-1:LEVEL_W]} >= bmag_reg);
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[LEVEL_W-2:0], qbit};
        end
        if (cmd.out_load)
        begin
            level_reg     <= level_next;
            degen_out_reg <= degen_reg;
        end
    end

    assign status.bypass = bypass_reg;
    assign level         = level_reg;
    assign degenerate    = degen_out_reg;

endmodule

/* hdl/min_max_normalize_nbits.sv */
// A measure transaction updates the running minimum and maximum and gives no result.
// A convert transaction passes through the prep, difference, multiply and load states,
// 32 steps of the radix-2 restoring divider and an output load; no pixel is accepted before it.
// Sentinel pixels and zero divisors skip the load and divider states.
// A finished result waits in the output register while measure transactions continue.
// Reset is asynchronous and active low; it restores the register defaults and running extremes.
module min_max_normalize_nbits import mmn_pkg::*;
#(
    parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    mmn_in_if.sink    pix,
    mmn_out_if.source res,
    mmn_cfg_if.sink   cfg
);

    cfg_t    cfg_q;
    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    mmn_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    mmn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_opcode (pix.opcode),
        .in_ready  (pix.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mmn_dp #(
        .PIXEL_WIDTH (PIXEL_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_q),
        .cmd        (cmd),
        .status     (status),
        .in_first   (pix.first),
        .in_pixel   (pix.pixel),
        .level      (res.level),
        .degenerate (res.degenerate)
    );

    // A new result must never overwrite one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!res.valid || res.ready))
        else $error("result register overwritten");

    // The block stops taking pixels once a convert transaction is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && pix.opcode == OP_CONVERT) |=> !pix.ready)
        else $error("input accepted during conversion");

    // The divider only runs while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !pix.ready)
        else $error("divider step while idle");

    // A degenerate result always carries level zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.degenerate) |-> (res.level == '0))
        else $error("degenerate result with nonzero level");

endmodule

/* test/tb_min_max_normalize_nbits.sv */
module tb_min_max_normalize_nbits;
    import mmn_pkg::*;

    localparam logic [PIX_FIELD_W-1:0] PIX_LO = 32'h8000_0000;
    localparam logic [PIX_FIELD_W-1:0] PIX_HI = 32'h7FFF_FFFF;
    localparam longint LEVEL_HI = 64'sd2147483647;
    localparam longint LEVEL_LO = -64'sd2147483648;
    localparam int RANDOM_PIXELS = 700;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               degenerate;
    } level_t;

    logic clk;
    logic rst_n;

    mmn_in_if  pix_bus ();
    mmn_out_if res_bus ();
    mmn_cfg_if cfg_bus ();

    min_max_normalize_nbits u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    logic [OUT_BITS_W-1:0]      depth_reg = OUT_BITS_RST;
    logic                       use_min_reg = USE_MIN_RST;
    logic signed [CFG_DATA_W-1:0] hint_reg = MAX_HINT_RST;
    logic signed [PIX_FIELD_W-1:0] track_min = PIX_HI;
    logic signed [PIX_FIELD_W-1:0] track_max = PIX_LO;

    level_t expected_levels[$];
    int     mismatches = 0;
    int     pixels_sent = 0;
    int     levels_checked = 0;
    int     reg_writes = 0;
    int     idle_max = 0;
    int     stall_max = 0;
    bit     pix_driving = 1'b0;
    bit     hold_req = 1'b0;
    logic   sink_hold = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic level_t scale_pixel(input logic [PIX_FIELD_W-1:0] px);
        longint v;
        longint lo;
        longint mx;
        longint imax;
        longint q;
        level_t r;
        v = longint'($signed(px));
        lo = longint'(track_min);
        mx = longint'(track_max);
        imax = (longint'(1) << depth_reg) - 1;
        if (mx < longint'(hint_reg) && hint_reg != PIX_HI)
        begin
            mx = longint'(hint_reg);
        end
        r.degenerate = 1'b0;
        if (use_min_reg && lo == mx)
        begin
            q = 0;
            r.degenerate = 1'b1;
        end
        else if (px == PIX_LO)
            q = 0;
        else if (px == PIX_HI)
            q = imax;
        else if (use_min_reg)
            q = (imax * (v - lo)) / (mx - lo);
        else if (mx == 0)
        begin
            q = 0;
            r.degenerate = 1'b1;
        end
        else
            q = (imax * v) / mx;
        if (q > LEVEL_HI)
            q = LEVEL_HI;
        else if (q < LEVEL_LO)
            q = LEVEL_LO;
        r.level = q[LEVEL_W-1:0];
        return r;
    endfunction

    function automatic void track_pixel(input logic frst, input logic [PIX_FIELD_W-1:0] px);
        if (frst)
        begin
            track_min = PIX_HI;
            track_max = PIX_LO;
        end
        if (px != PIX_LO && px != PIX_HI)
        begin
            if ($signed(px) > track_max)
                track_max = px;
            if ($signed(px) < track_min)
                track_min = px;
        end
    endfunction

    function automatic logic [PIX_FIELD_W-1:0] pick_pixel();
        case ($urandom_range(0, 11))
            0: return PIX_LO;
            1: return PIX_HI;
            2: return PIX_LO + 1'b1;
            3: return PIX_HI - 1'b1;
            4, 5, 6: return $urandom;
            default: return $urandom_range(0, 4000) - 32'd2000;
        endcase
    endfunction

    task automatic send_pixel(input logic op, input logic frst,
                              input logic [PIX_FIELD_W-1:0] px, input bit more);
        int gap;
        gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        if (gap != 0)
        begin
            if (pix_driving)
                pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid  <= 1'b1;
        pix_bus.opcode <= op;
        pix_bus.first  <= frst;
        pix_bus.pixel  <= px;
        do @(posedge clk); while (!pix_bus.ready);
        pixels_sent++;
        if (op == OP_CONVERT)
            expected_levels.push_back(scale_pixel(px));
        else
            track_pixel(frst, px);
        pix_driving = more;
        if (!more)
            pix_bus.valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_OUT_BITS: depth_reg = val[OUT_BITS_W-1:0];
            REG_USE_MIN:  use_min_reg = val[0];
            REG_MAX_HINT: hint_reg = val;
            default: ;
        endcase
    endtask

    task automatic settle();
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_level(input logic [LEVEL_W-1:0] lvl, input logic dg);
        level_t want;
        if (expected_levels.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result level=%h degenerate=%b", $time, lvl, dg);
        end
        else
        begin
            want = expected_levels.pop_front();
            levels_checked++;
            if (lvl !== want.level)
            begin
                mismatches++;
                $display("%0t: level expected %h actual %h", $time, want.level, lvl);
            end
            if (dg !== want.degenerate)
            begin
                mismatches++;
                $display("%0t: degenerate expected %b actual %b", $time, want.degenerate, dg);
            end
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (res_bus.valid && res_bus.ready)
                begin
                    check_level(res_bus.level, res_bus.degenerate);
                    stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
                end
                res_bus.ready <= !(sink_hold || stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    initial
    begin : hold_off
        forever
        begin
            wait (hold_req);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
            hold_req = 1'b0;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // With nothing measured, the reset extremes act as the range.
    task automatic test_unmeasured();
        send_pixel(OP_CONVERT, 1'b1, 32'd0, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_LO, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_HI, 1'b0);
        settle();
    endtask

    task automatic test_min_max_scaling();
        write_reg(REG_OUT_BITS, 32'd31);
        send_pixel(OP_MEASURE, 1'b1, -32'sd100, 1'b1);
        send_pixel(OP_MEASURE, 1'b0, 32'd100, 1'b1);
        send_pixel(OP_MEASURE, 1'b0, PIX_LO, 1'b1);
        send_pixel(OP_MEASURE, 1'b0, PIX_HI, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, -32'sd100, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, 32'd0, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, 32'd100, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_HI - 1'b1, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_LO + 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_flat_image();
        send_pixel(OP_MEASURE, 1'b1, 32'd5, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, 32'd5, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_LO, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_HI, 1'b0);
        settle();
    endtask

    task automatic test_max_only();
        write_reg(REG_USE_MIN, 32'd0);
        write_reg(REG_OUT_BITS, 32'd8);
        send_pixel(OP_MEASURE, 1'b1, 32'd0, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, 32'd3, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_LO, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, PIX_HI, 1'b0);
        settle();
        write_reg(REG_MAX_HINT, 32'd1000);
        send_pixel(OP_CONVERT, 1'b0, 32'd500, 1'b0);
        settle();
    endtask

    task automatic test_zero_depth();
        write_reg(REG_OUT_BITS, 32'd0);
        write_reg(REG_USE_MIN, 32'd1);
        write_reg(REG_MAX_HINT, PIX_HI);
        send_pixel(OP_MEASURE, 1'b1, -32'sd7, 1'b1);
        send_pixel(OP_MEASURE, 1'b0, 32'd9, 1'b1);
        send_pixel(OP_CONVERT, 1'b0, 32'd1, 1'b0);
        settle();
    endtask

    task automatic pick_setting();
        logic [OUT_BITS_W-1:0] depth;
        logic [CFG_DATA_W-1:0] hint;
        case ($urandom_range(0, 4))
            0: depth = '0;
            1: depth = 5'd1;
            2: depth = 5'd31;
            default: depth = 5'($urandom_range(1, 31));
        endcase
        case ($urandom_range(0, 5))
            0: hint = PIX_HI;
            1: hint = PIX_LO;
            2: hint = '0;
            3: hint = PIX_HI - 1'b1;
            4: hint = $urandom_range(0, 4000) - 32'd2000;
            default: hint = $urandom;
        endcase
        if ($urandom_range(0, 1))
            write_reg(REG_OUT_BITS, {27'($urandom), depth});
        if ($urandom_range(0, 1))
            write_reg(REG_USE_MIN, {31'($urandom), 1'($urandom)});
        if ($urandom_range(0, 1))
            write_reg(REG_MAX_HINT, hint);
    endtask

    task automatic run_image(input int n_meas, input int n_conv, input bit restart);
        logic frst;
        for (int i = 0; i < n_meas; i++)
        begin
            frst = (i == 0) ? restart : ($urandom_range(0, 15) == 0);
            send_pixel(OP_MEASURE, frst, pick_pixel(), 1'b1);
        end
        for (int i = 0; i < n_conv; i++)
            send_pixel(OP_CONVERT, 1'($urandom), pick_pixel(), i != n_conv - 1);
    endtask

    task automatic test_random_images();
        int start;
        int n_meas;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 2))
                0: idle_max = 0;
                1: idle_max = 4;
                default: idle_max = 16;
            endcase
            case ($urandom_range(0, 2))
                0: stall_max = 0;
                1: stall_max = 4;
                default: stall_max = 16;
            endcase
            pick_setting();
            n_meas = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            run_image(n_meas, $urandom_range(1, 10), $urandom_range(0, 7) != 0);
            settle();
        end
        idle_max = 0;
        stall_max = 0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_USE_MIN, 32'd1);
        write_reg(REG_OUT_BITS, 32'd16);
        send_pixel(OP_MEASURE, 1'b1, 32'd0, 1'b1);
        send_pixel(OP_MEASURE, 1'b0, 32'd1000, 1'b1);
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_pixel(OP_CONVERT, 1'b0, $urandom_range(0, 1200), i != 23);
        settle();
    endtask

    initial
    begin : main
        rst_n = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.opcode = OP_MEASURE;
        pix_bus.first = 1'b0;
        pix_bus.pixel = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_OUT_BITS;
        cfg_bus.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unmeasured();
        test_min_max_scaling();
        test_flat_image();
        test_max_only();
        test_zero_depth();
        test_random_images();
        test_backpressure();

        $display("Sent %0d pixel transactions and %0d register writes.", pixels_sent, reg_writes);
        $display("Checked %0d levels, with one %0d-cycle result hold-off.",
                 levels_checked, HOLD_CYCLES);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
